// ===== rtl/assert_macros.svh =====
// assertion helpers used by the pvf_checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define PVF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pvf assertion failed");

// property checked on every rising edge, reset included
`define PVF_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pvf assertion failed");

`endif

// ===== rtl/pvf_pkg.sv =====
package pvf_pkg;

    localparam int DATA_W = 16;   // intensity and stool maximum
    localparam int OFF_W  = 12;   // air offset register
    localparam int NUM_W  = DATA_W + 2;  // signed sums of data and offset
    localparam int MAG_W  = 16;   // magnitude of any numerator or divisor
    localparam int CLS_W  = 3;

    localparam logic [OFF_W-1:0] OFF_RESET = 12'd1000;

    // voxel class codes
    localparam logic [CLS_W-1:0] CLS_AIR    = 3'd0;
    localparam logic [CLS_W-1:0] CLS_TISSUE = 3'd1;
    localparam logic [CLS_W-1:0] CLS_STOOL  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_TA     = 3'd3;
    localparam logic [CLS_W-1:0] CLS_TS     = 3'd4;
    localparam logic [CLS_W-1:0] CLS_SA     = 3'd5;
    localparam logic [CLS_W-1:0] CLS_UNCL   = 3'd6;

    // how the clamped quotient is settled
    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_ONE  = 2'd1;
    localparam logic [1:0] KIND_DIV  = 2'd2;

    typedef struct packed {
        logic             mask;
        logic [CLS_W-1:0] cls;
        logic [1:0]       kind;
    } t_meta;

endpackage

// ===== rtl/pvf_div_pipe.sv =====
module pvf_div_pipe import pvf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_meta                i_meta,
    input  logic [MAG_W-1:0]     i_rem,
    input  logic [MAG_W-1:0]     i_den,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_meta                o_meta,
    output logic [FRAC_BITS-1:0] o_quo
);

    // one restoring step per stage, quotient msb first; remainder stays below divisor

    logic                 r_v    [FRAC_BITS];
    t_meta                r_meta [FRAC_BITS];
    logic [MAG_W-1:0]     r_rem  [FRAC_BITS];
    logic [MAG_W-1:0]     r_den  [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_quo  [FRAC_BITS];

    logic                 w_src_v    [FRAC_BITS];
    t_meta                w_src_meta [FRAC_BITS];
    logic [MAG_W-1:0]     w_src_rem  [FRAC_BITS];
    logic [MAG_W-1:0]     w_src_den  [FRAC_BITS];
    logic [FRAC_BITS-1:0] w_src_quo  [FRAC_BITS];
    logic                 w_rdy      [FRAC_BITS+1];

    always_comb begin
        w_src_v[0]    = i_valid;
        w_src_meta[0] = i_meta;
        w_src_rem[0]  = i_rem;
        w_src_den[0]  = i_den;
        w_src_quo[0]  = '0;
        for (int k = 1; k < FRAC_BITS; k++) begin
            w_src_v[k]    = r_v[k-1];
            w_src_meta[k] = r_meta[k-1];
            w_src_rem[k]  = r_rem[k-1];
            w_src_den[k]  = r_den[k-1];
            w_src_quo[k]  = r_quo[k-1];
        end
    end

    // a stage takes new data when empty or when its content moves on
    always_comb begin
        w_rdy[FRAC_BITS] = i_ready;
        for (int k = FRAC_BITS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
        logic [MAG_W:0] n_trial;
        logic [MAG_W:0] n_diff;
        logic           n_bit;

        always_comb begin
            n_trial = {w_src_rem[k], 1'b0};
            n_diff  = n_trial - {1'b0, w_src_den[k]};
            n_bit   = n_trial >= {1'b0, w_src_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_v[k] <= w_src_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && w_src_v[k]) begin
                r_meta[k] <= w_src_meta[k];
                r_den[k]  <= w_src_den[k];
                r_rem[k]  <= n_bit ? n_diff[MAG_W-1:0] : n_trial[MAG_W-1:0];
                r_quo[k]  <= {w_src_quo[k][FRAC_BITS-2:0], n_bit};
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[FRAC_BITS-1];
    assign o_meta  = r_meta[FRAC_BITS-1];
    assign o_quo   = r_quo[FRAC_BITS-1];

endmodule

// ===== rtl/partial_volume_fractions.sv =====
// throughput: one voxel per cycle while not stalled; the quotient is built by a chain of FRAC_BITS
// restoring-divide stages, one quotient bit per stage, plus three prep stages and an output register
// stalls back up stage by stage, empty stages fill while the output waits
// reset: synchronous active-low i_rst_n clears all valid bits and loads air_offset with 1000
module partial_volume_fractions import pvf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: air_offset
    input  logic                   i_cfg_we,
    input  logic [OFF_W-1:0]       i_cfg_wdata,
    // voxel input
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [2*DATA_W-1:0]    i_s_axis_tdata,  // intensity [15:0], stool_max [31:16]
    input  logic [CLS_W:0]         i_s_axis_tuser,  // in_mask [0], voxel_class [3:1]
    // fraction output
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] o_m_axis_tdata
        // air_frac, tissue_frac, stool_frac, FRAC_BITS+1 bits each from bit 0, zero padded
);

    localparam int FW    = FRAC_BITS + 1;
    localparam int OUT_W = ((3 * FW + 7) / 8) * 8;

    localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // air offset register; the user must write it only while idle, the block does not enforce this
    logic [OFF_W-1:0] r_air_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air_offset <= OFF_RESET;
        end else if (i_cfg_we) begin
            r_air_offset <= i_cfg_wdata;
        end
    end

    // ready chain: output register, divider pipe, stage 3, stage 2, stage 1
    logic w_rdy_out, w_rdy_div, w_rdy3, w_rdy2, w_rdy1;

    logic r_v1, r_v2, r_v3, r_o_valid;

    assign w_rdy_out = !r_o_valid || i_m_axis_tready;
    assign w_rdy3    = !r_v3 || w_rdy_div;
    assign w_rdy2    = !r_v2 || w_rdy3;
    assign w_rdy1    = !r_v1 || w_rdy2;
    assign o_s_axis_tready = w_rdy1;

    // ---------------- stage 1: form signed numerator and divisor ----------------
    // tissue-air: (I+off)/off, tissue-stool: I/S, stool-air: (I+off)/(S+off)
    logic signed [NUM_W-1:0] n_int, n_smax, n_off, n_num, n_den;
    logic [CLS_W-1:0]        n_cls;
    t_meta                   n_meta1;

    always_comb begin
        n_cls  = i_s_axis_tuser[CLS_W:1];
        n_int  = {{(NUM_W-DATA_W){i_s_axis_tdata[DATA_W-1]}}, i_s_axis_tdata[DATA_W-1:0]};
        n_smax = {{(NUM_W-DATA_W){i_s_axis_tdata[2*DATA_W-1]}},
                  i_s_axis_tdata[2*DATA_W-1:DATA_W]};
        n_off  = {{(NUM_W-OFF_W){1'b0}}, r_air_offset};
        n_num  = n_int + (((n_cls == CLS_TA) || (n_cls == CLS_SA)) ? n_off : '0);
        if (n_cls == CLS_TA) begin
            n_den = n_off;
        end else begin
            n_den = n_smax + ((n_cls == CLS_SA) ? n_off : '0);
        end
        n_meta1.mask = i_s_axis_tuser[0];
        n_meta1.cls  = n_cls;
        n_meta1.kind = KIND_DIV;
    end

    t_meta                   r_meta1;
    logic signed [NUM_W-1:0] r_num1, r_den1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_s_axis_tvalid) begin
            r_meta1 <= n_meta1;
            r_num1  <= n_num;
            r_den1  <= n_den;
        end
    end

    // ---------------- stage 2: zero and sign test, magnitudes ----------------
    // zero divisor, zero numerator or opposite signs all give a zero quotient
    logic                    n_zero;
    logic signed [NUM_W-1:0] n_abs_num, n_abs_den;
    t_meta                   n_meta2;

    always_comb begin
        n_zero = (r_num1 == '0) || (r_den1 == '0) ||
                 (r_num1[NUM_W-1] != r_den1[NUM_W-1]);
        n_abs_num = r_num1[NUM_W-1] ? -r_num1 : r_num1;
        n_abs_den = r_den1[NUM_W-1] ? -r_den1 : r_den1;
        n_meta2      = r_meta1;
        n_meta2.kind = n_zero ? KIND_ZERO : KIND_DIV;
    end

    t_meta            r_meta2;
    logic [MAG_W-1:0] r_an2, r_ad2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_meta2 <= n_meta2;
            r_an2   <= n_abs_num[MAG_W-1:0];
            r_ad2   <= n_abs_den[MAG_W-1:0];
        end
    end

    // ---------------- stage 3: clamp at one ----------------
    // a ratio of one or more saturates; otherwise the divider sees num < den
    t_meta n_meta3;

    always_comb begin
        n_meta3 = r_meta2;
        if (r_meta2.kind == KIND_DIV && r_an2 >= r_ad2) begin
            n_meta3.kind = KIND_ONE;
        end
    end

    t_meta            r_meta3;
    logic [MAG_W-1:0] r_an3, r_ad3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_meta3 <= n_meta3;
            r_an3   <= r_an2;
            r_ad3   <= r_ad2;
        end
    end

    // ---------------- divider: floor(an * 2^FRAC_BITS / ad) ----------------
    logic                 w_div_valid;
    t_meta                w_div_meta;
    logic [FRAC_BITS-1:0] w_div_quo;

    pvf_div_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .o_ready (w_rdy_div),
        .i_meta  (r_meta3),
        .i_rem   (r_an3),
        .i_den   (r_ad3),
        .o_valid (w_div_valid),
        .i_ready (w_rdy_out),
        .o_meta  (w_div_meta),
        .o_quo   (w_div_quo)
    );

    // ---------------- output stage: spread quotient over the fractions ----------------
    logic [FW-1:0]    n_q, n_air, n_tis, n_stl;
    logic [OUT_W-1:0] n_tdata;

    always_comb begin
        unique case (w_div_meta.kind)
            KIND_ONE: n_q = ONE;
            KIND_DIV: n_q = {1'b0, w_div_quo};
            default:  n_q = '0;
        endcase
        n_air = '0;
        n_tis = '0;
        n_stl = '0;
        if (w_div_meta.mask) begin
            unique case (w_div_meta.cls)
                CLS_AIR:    n_air = ONE;
                CLS_TISSUE: n_tis = ONE;
                CLS_STOOL:  n_stl = ONE;
                CLS_TA: begin
                    n_tis = n_q;
                    n_air = ONE - n_q;
                end
                CLS_TS: begin
                    n_stl = n_q;
                    n_tis = ONE - n_q;
                end
                CLS_SA: begin
                    n_stl = n_q;
                    n_air = ONE - n_q;
                end
                default: begin
                    // unclassified and unused codes leave all zeros
                end
            endcase
        end
        n_tdata               = '0;
        n_tdata[FW-1:0]       = n_air;
        n_tdata[2*FW-1:FW]    = n_tis;
        n_tdata[3*FW-1:2*FW]  = n_stl;
    end

    logic [OUT_W-1:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_rdy_out) begin
            r_o_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_out && w_div_valid) begin
            r_o_data <= n_tdata;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = r_o_data;

endmodule

// ===== rtl/pvf_checker.sv =====
`include "assert_macros.svh"

module pvf_checker #(
    parameter int FRAC_BITS = 16
) (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_m_tvalid,
    input logic                                    i_m_tready,
    input logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0]    i_m_tdata
);

    localparam int FW = FRAC_BITS + 1;

    logic [FW-1:0] w_air, w_tis, w_stl;
    logic [FW+1:0] w_sum;
    logic [FW+1:0] w_one;

    assign w_air = i_m_tdata[FW-1:0];
    assign w_tis = i_m_tdata[2*FW-1:FW];
    assign w_stl = i_m_tdata[3*FW-1:2*FW];
    assign w_sum = {2'b00, w_air} + {2'b00, w_tis} + {2'b00, w_stl};
    assign w_one = {2'b00, 1'b1, {FRAC_BITS{1'b0}}};

    // a result waits until taken
    `PVF_ASSERT(a_valid_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid)

    // a waiting result keeps its data
    `PVF_ASSERT(a_data_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata))

    // fractions are either all zero or add up to exactly one
    `PVF_ASSERT(a_sum_one, i_clk, i_rst_n, i_m_tvalid |-> (w_sum == w_one || w_sum == '0))

    // at most two classes share a voxel
    `PVF_ASSERT(a_two_max, i_clk, i_rst_n, i_m_tvalid |-> $countones({w_air != '0, w_tis != '0, w_stl != '0}) <= 2)

    // reset empties the pipeline
    `PVF_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_m_tvalid)

endmodule

bind partial_volume_fractions pvf_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_pvf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

// ===== sim/pvf_fraction_checker.sv =====
`timescale 1ns / 100ps
module pvf_fraction_checker import pvf_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int OUT_W     = ((3*(FRAC_BITS+1)+7)/8)*8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [OFF_W-1:0]   i_cfg_wdata,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [2*DATA_W-1:0] i_s_tdata,   // intensity, stool_max
    input  logic [CLS_W:0]     i_s_tuser,    // in_mask, voxel_class
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [OUT_W-1:0]   i_m_tdata,    // air_frac, tissue_frac, stool_frac
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int FW = FRAC_BITS + 1;
    localparam logic [FW-1:0] ONE_Q = FW'(1) << FRAC_BITS;

    // packed msb first, so air lands in the low bits as on the bus
    typedef struct packed {
        logic [FW-1:0] stool;
        logic [FW-1:0] tissue;
        logic [FW-1:0] air;
    } t_fractions;

    t_fractions       expected_fracs [$];
    logic [OFF_W-1:0] air_offset;
    int               fail_count = 0;
    int               pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    // num/den clamped to [0, 1] in Q1.FRAC_BITS, zero divisor gives zero
    function automatic logic [FW-1:0] clamped_ratio(longint num, longint den);
        longint an, ad;
        if (den == 0 || num == 0)
            return '0;
        if ((num < 0) != (den < 0))
            return '0;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        if (an >= ad)
            return ONE_Q;
        return FW'((an << FRAC_BITS) / ad);
    endfunction

    function automatic t_fractions predict_fractions(logic mask, logic [CLS_W-1:0] cls,
                                                     logic signed [DATA_W-1:0] inten,
                                                     logic signed [DATA_W-1:0] smax,
                                                     logic [OFF_W-1:0] offset);
        t_fractions f;
        longint     i_v, s_v, o_v;
        logic [FW-1:0] q;
        f   = '0;
        i_v = inten;
        s_v = smax;
        o_v = longint'(offset);
        if (mask) begin
            case (cls)
                CLS_AIR:    f.air    = ONE_Q;
                CLS_TISSUE: f.tissue = ONE_Q;
                CLS_STOOL:  f.stool  = ONE_Q;
                CLS_TA: begin
                    q        = clamped_ratio(i_v + o_v, o_v);
                    f.tissue = q;
                    f.air    = ONE_Q - q;
                end
                CLS_TS: begin
                    q        = clamped_ratio(i_v, s_v);
                    f.stool  = q;
                    f.tissue = ONE_Q - q;
                end
                CLS_SA: begin
                    q       = clamped_ratio(i_v + o_v, s_v + o_v);
                    f.stool = q;
                    f.air   = ONE_Q - q;
                end
                default: ;
            endcase
        end
        return f;
    endfunction

    // append one prediction at the tail of the queue
    function automatic void queue_prediction(t_fractions f);
        expected_fracs.insert(expected_fracs.size(), f);
    endfunction

    task automatic check_field(string label, logic [FW-1:0] exp_v, logic [FW-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, label, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_fractions got, want;
        if (!i_rst_n) begin
            air_offset <= OFF_RESET;
            expected_fracs.delete();
            pending_cnt = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_fractions'(i_m_tdata[3*FW-1:0]);
                if (expected_fracs.size() == 0) begin
                    $display("%0t: unexpected transfer, expected none actual %0d %0d %0d",
                             $time, got.air, got.tissue, got.stool);
                    fail_count++;
                end else begin
                    want = expected_fracs.pop_front();
                    check_field("air_frac", want.air, got.air);
                    check_field("tissue_frac", want.tissue, got.tissue);
                    check_field("stool_frac", want.stool, got.stool);
                end
            end
            if (i_s_tvalid && i_s_tready)
                queue_prediction(predict_fractions(i_s_tuser[0], i_s_tuser[CLS_W:1],
                                                   i_s_tdata[DATA_W-1:0],
                                                   i_s_tdata[2*DATA_W-1:DATA_W],
                                                   air_offset));
            if (i_cfg_we)
                air_offset <= i_cfg_wdata;
            pending_cnt = expected_fracs.size();
        end
    end

endmodule

// ===== sim/tb_partial_volume_fractions.sv =====
`timescale 1ns / 100ps
module tb_partial_volume_fractions;
    import pvf_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = ((3*(FRAC_BITS+1)+7)/8)*8;
    localparam int LATENCY   = FRAC_BITS + 4;
    localparam int PHASES    = 5;
    localparam int PHASE_LEN = 250;
    // class code with no meaning, the block must give all zeros
    localparam logic [CLS_W-1:0] CLS_UNUSED = 3'd7;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [OFF_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [2*DATA_W-1:0] s_tdata = '0;   // intensity [15:0], stool_max [31:16]
    logic [CLS_W:0]      s_tuser = '0;   // in_mask [0], voxel_class [3:1]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;        // air_frac, tissue_frac, stool_frac from bit 0
    int                  fail_count;
    int                  pending;

    // idle odds in percent per cycle, changed between phases
    int                  src_idle_pct = 36;
    int                  sink_idle_pct = 63;
    // air offset the block currently holds, used to aim the stimulus
    logic [OFF_W-1:0]    cur_offset = OFF_RESET;

    always #1 clk = ~clk;

    partial_volume_fractions #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    pvf_fraction_checker #(.FRAC_BITS(FRAC_BITS), .OUT_W(OUT_W)) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // output backpressure, one fresh draw per cycle
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // hard stop in case the pipeline hangs
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

    // one voxel transfer, with random idle cycles in front of it
    task automatic send_voxel(input logic mask, input logic [CLS_W-1:0] cls,
                              input logic signed [DATA_W-1:0] inten,
                              input logic signed [DATA_W-1:0] smax);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {smax, inten};
        s_tuser  <= {cls, mask};
        do @(posedge clk); while (!s_tready);
    endtask

    // drop valid and let every outstanding voxel come out
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // register write, only ever issued with the pipeline empty
    task automatic load_air_offset(input logic [OFF_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_offset  = value;
    endtask

    function automatic logic signed [DATA_W-1:0] sat16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return DATA_W'(v);
    endfunction

    // mostly boundary classes with intensities aimed inside the (0,1) ratio band,
    // the rest fully random words so every bit toggles and the clamps get hit
    task automatic random_voxel();
        logic           mask;
        logic [CLS_W-1:0] cls;
        longint         i_v, s_v, o_v, d_v;
        int             pick;
        o_v  = longint'(cur_offset);
        mask = ($urandom_range(0, 9) != 0);
        pick = $urandom_range(0, 9);
        if (pick < 2)
            cls = CLS_W'($urandom_range(0, 7));
        else
            cls = CLS_TA + CLS_W'(pick % 3);
        i_v = longint'($signed(16'($urandom)));
        s_v = longint'($signed(16'($urandom)));
        if ($urandom_range(0, 3) != 0) begin
            case (cls)
                CLS_TA: begin
                    // intensity between minus offset and zero: tissue in [0, 1]
                    i_v = longint'($urandom_range(0, int'(o_v))) - o_v;
                end
                CLS_TS: begin
                    if ($urandom_range(0, 15) == 0)
                        s_v = 0;
                    i_v = (s_v * longint'($urandom_range(0, 1024))) / 1024;
                end
                CLS_SA: begin
                    // sometimes put the divisor exactly at zero
                    if ($urandom_range(0, 7) == 0)
                        s_v = -o_v;
                    d_v = s_v + o_v;
                    i_v = (d_v * longint'($urandom_range(0, 1024))) / 1024 - o_v;
                end
                default: ;
            endcase
        end
        send_voxel(mask, cls, sat16(i_v), sat16(s_v));
    endtask

    initial begin
        logic [OFF_W-1:0] phase_offset [PHASES];
        phase_offset = '{12'd4095, 12'd1, 12'($urandom_range(1, 4095)),
                         12'($urandom_range(1, 4095)), OFF_RESET};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed voxels at the reset offset of 1000
        // outside the mask: all zeros whatever the class
        send_voxel(1'b0, CLS_TS, 16'sd100, 16'sd200);
        send_voxel(1'b0, CLS_AIR, -16'sd1, -16'sd1);
        // pure classes, unclassified and the unused code
        send_voxel(1'b1, CLS_AIR, 16'sh7FFF, 16'sh8000);
        send_voxel(1'b1, CLS_TISSUE, 16'sh8000, 16'sh7FFF);
        send_voxel(1'b1, CLS_STOOL, 16'sd0, 16'sd0);
        send_voxel(1'b1, CLS_UNCL, 16'sd500, 16'sd900);
        send_voxel(1'b1, CLS_UNUSED, -16'sd500, 16'sd900);
        // tissue-air: zero numerator, exactly one, half, both clamps, just above zero
        send_voxel(1'b1, CLS_TA, -16'sd1000, 16'sd0);
        send_voxel(1'b1, CLS_TA, 16'sd0, 16'sd0);
        send_voxel(1'b1, CLS_TA, -16'sd500, 16'sd0);
        send_voxel(1'b1, CLS_TA, 16'sh8000, 16'sd0);
        send_voxel(1'b1, CLS_TA, 16'sh7FFF, 16'sd0);
        send_voxel(1'b1, CLS_TA, -16'sd999, 16'sd0);
        // tissue-stool: zero divisor, zero numerator, equal, both negative,
        // opposite signs, extreme words
        send_voxel(1'b1, CLS_TS, 16'sd5, 16'sd0);
        send_voxel(1'b1, CLS_TS, 16'sd0, 16'sd7);
        send_voxel(1'b1, CLS_TS, -16'sd1234, -16'sd1234);
        send_voxel(1'b1, CLS_TS, -16'sd1, -16'sd2);
        send_voxel(1'b1, CLS_TS, 16'sd1, -16'sd2);
        send_voxel(1'b1, CLS_TS, 16'sh8000, 16'sh7FFF);
        send_voxel(1'b1, CLS_TS, 16'sh7FFF, 16'sh8000);
        send_voxel(1'b1, CLS_TS, 16'sh8000, 16'sh8000);
        send_voxel(1'b1, CLS_TS, 16'sd1, 16'sh7FFF);
        // stool-air: divisor cancels to zero, zero numerator, both sums negative, equal
        send_voxel(1'b1, CLS_SA, 16'sd300, -16'sd1000);
        send_voxel(1'b1, CLS_SA, -16'sd1000, 16'sd500);
        send_voxel(1'b1, CLS_SA, -16'sd1001, 16'sh8000);
        send_voxel(1'b1, CLS_SA, 16'sd300, 16'sd300);

        // random phases: offset extremes first, then idle patterns swap, then none
        for (int p = 0; p < PHASES; p++) begin
            drain_pipeline();
            if (p < 2) begin
                src_idle_pct  = 36;
                sink_idle_pct = 63;
            end else if (p < 4) begin
                src_idle_pct  = 63;
                sink_idle_pct = 36;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            load_air_offset(phase_offset[p]);
            repeat (PHASE_LEN) random_voxel();
        end

        drain_pipeline();
        repeat (LATENCY + 5) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
